### hdl/ole_pkg.sv
`default_nettype none

package ole_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_O_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT   = 3'd0,
    CMD_INSERT_AFTER = 3'd1,
    CMD_PUSH_BACK    = 3'd2,
    CMD_POP_FRONT    = 3'd3,
    CMD_REMOVE_KEY   = 3'd4,
    CMD_POP_BACK     = 3'd5,
    CMD_SEARCH       = 3'd6,
    CMD_LIST         = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_ALLOC,
    S_LINK,
    S_LINK_PRED,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture input transaction
    logic    walk_start;  // read head node
    logic    walk_step;   // follow next pointer
    logic    fs_read;     // read top of free stack
    logic    alloc;       // claim a node slot
    logic    link;        // write new node, fix head/tail
    logic    link_pred;   // point found node at new node
    logic    remove;      // unlink current node
    logic    set_status;
    status_e status_val;
    logic    emit_resp;   // single result from status register
    logic    emit_elem;   // listed element result
  } ole_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic full;
    logic match;     // current node equals key
    logic at_end;    // current node is the back entry
    logic out_free;  // output register can take a transaction
  } ole_stat_t;

endpackage

`default_nettype wire

### hdl/ole_ctrl.sv
`default_nettype none

module ole_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire ole_pkg::ole_stat_t stat_i,
  output ole_pkg::ole_cmd_t   cmd_o
);

  ole_pkg::state_e state_q, state_d;
  logic            hit;

  // node that ends the walk successfully
  always_comb begin
    case (stat_i.cmd)
      ole_pkg::CMD_INSERT_AFTER,
      ole_pkg::CMD_REMOVE_KEY,
      ole_pkg::CMD_SEARCH:    hit = stat_i.match;
      ole_pkg::CMD_POP_FRONT: hit = 1'b1;
      ole_pkg::CMD_POP_BACK:  hit = stat_i.at_end;
      default:                hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ole_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ole_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ole_pkg::S_DECODE;
      end
      ole_pkg::S_DECODE: begin
        case (stat_i.cmd)
          ole_pkg::CMD_PUSH_FRONT,
          ole_pkg::CMD_PUSH_BACK: begin
            state_d = stat_i.full ? ole_pkg::S_RESP : ole_pkg::S_ALLOC;
          end
          default: begin
            state_d = stat_i.empty ? ole_pkg::S_RESP : ole_pkg::S_WALK;
          end
        endcase
      end
      ole_pkg::S_WALK: begin
        if (stat_i.cmd == ole_pkg::CMD_LIST) begin
          if (stat_i.out_free && stat_i.at_end) state_d = ole_pkg::S_IDLE;
        end else if (hit) begin
          if (stat_i.cmd == ole_pkg::CMD_INSERT_AFTER && !stat_i.full) begin
            state_d = ole_pkg::S_ALLOC;
          end else begin
            state_d = ole_pkg::S_RESP;
          end
        end else if (stat_i.at_end) begin
          state_d = ole_pkg::S_RESP;
        end
      end
      ole_pkg::S_ALLOC: state_d = ole_pkg::S_LINK;
      ole_pkg::S_LINK: begin
        state_d = (stat_i.cmd == ole_pkg::CMD_INSERT_AFTER) ? ole_pkg::S_LINK_PRED
                                                            : ole_pkg::S_RESP;
      end
      ole_pkg::S_LINK_PRED: state_d = ole_pkg::S_RESP;
      ole_pkg::S_RESP: begin
        if (stat_i.out_free) state_d = ole_pkg::S_IDLE;
      end
      default: state_d = ole_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ole_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ole_pkg::S_DECODE: begin
        case (stat_i.cmd)
          ole_pkg::CMD_PUSH_FRONT,
          ole_pkg::CMD_PUSH_BACK: begin
            if (stat_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = ole_pkg::ST_FULL;
            end else begin
              cmd_o.fs_read = 1'b1;
            end
          end
          ole_pkg::CMD_INSERT_AFTER,
          ole_pkg::CMD_SEARCH: begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = ole_pkg::ST_NOT_FOUND;
            end else begin
              cmd_o.walk_start = 1'b1;
            end
          end
          default: begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = ole_pkg::ST_EMPTY;
            end else begin
              cmd_o.walk_start = 1'b1;
            end
          end
        endcase
      end
      ole_pkg::S_WALK: begin
        if (stat_i.cmd == ole_pkg::CMD_LIST) begin
          if (stat_i.out_free) begin
            cmd_o.emit_elem = 1'b1;
            cmd_o.walk_step = !stat_i.at_end;
          end
        end else if (hit) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ole_pkg::ST_OK;
          case (stat_i.cmd)
            ole_pkg::CMD_INSERT_AFTER: begin
              if (stat_i.full) begin
                cmd_o.status_val = ole_pkg::ST_FULL;
              end else begin
                cmd_o.set_status = 1'b0;
                cmd_o.fs_read    = 1'b1;
              end
            end
            ole_pkg::CMD_SEARCH: ;
            default: cmd_o.remove = 1'b1;
          endcase
        end else if (stat_i.at_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ole_pkg::ST_NOT_FOUND;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ole_pkg::S_ALLOC: cmd_o.alloc = 1'b1;
      ole_pkg::S_LINK: begin
        cmd_o.link = 1'b1;
        if (stat_i.cmd != ole_pkg::CMD_INSERT_AFTER) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ole_pkg::ST_OK;
        end
      end
      ole_pkg::S_LINK_PRED: begin
        cmd_o.link_pred  = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status_val = ole_pkg::ST_OK;
      end
      ole_pkg::S_RESP: cmd_o.emit_resp = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hdl/ole_dpath.sv
`default_nettype none

module ole_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire ole_pkg::ole_cmd_t               cmd_i,
  output ole_pkg::ole_stat_t                   stat_o,
  input  wire [ole_pkg::CMD_W-1:0]             command_i,
  input  wire signed [ole_pkg::DATA_W-1:0]     match_key_i,
  input  wire signed [ole_pkg::DATA_W-1:0]     new_value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [ole_pkg::STATUS_W-1:0]         status_o,
  output logic signed [ole_pkg::DATA_W-1:0]    element_o,
  output logic                                 last_o,
  output logic [ole_pkg::COUNT_O_W-1:0]        entry_count_o,
  output logic signed [ole_pkg::DATA_W-1:0]    value_sum_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = ole_pkg::DATA_W;

  // node store: value and next pointer per slot, plus stack of freed slots
  logic signed [DW-1:0] val_mem [DEPTH];
  logic [IW-1:0]        nxt_mem [DEPTH];
  logic [IW-1:0]        fs_mem  [DEPTH];

  ole_pkg::cmd_e        cmd_q;
  logic signed [DW-1:0] key_q, val_q;
  logic [IW-1:0]        head_q, tail_q, cur_q, prev_q, pos_q, new_q;
  logic [CW-1:0]        cnt_q, bump_q, fs_cnt_q;
  logic signed [DW-1:0] sum_q;
  ole_pkg::status_e     status_q;
  logic signed [DW-1:0] rd_val_q;
  logic [IW-1:0]        rd_nxt_q, fs_rd_q;

  logic                 out_valid_q, out_last_q;
  ole_pkg::status_e     out_status_q;
  logic signed [DW-1:0] out_elem_q, out_sum_q;
  logic [ole_pkg::COUNT_O_W-1:0] out_cnt_q;

  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [CW-1:0]        fs_top;
  logic                 nxt_we;
  logic [IW-1:0]        nxt_wa, nxt_wd;
  logic                 at_end, out_free;

  assign at_end   = (CW'(pos_q) + CW'(1)) == cnt_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign fs_top   = fs_cnt_q - CW'(1);

  assign stat_o.cmd      = cmd_q;
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.full     = (cnt_q == CW'(DEPTH));
  assign stat_o.match    = (rd_val_q == key_q);
  assign stat_o.at_end   = at_end;
  assign stat_o.out_free = out_free;

  assign rd_en   = cmd_i.walk_start || cmd_i.walk_step;
  assign rd_addr = cmd_i.walk_start ? head_q : rd_nxt_q;

  // next-pointer write port
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = new_q;
    nxt_wd = head_q;
    if (cmd_i.link) begin
      case (cmd_q)
        ole_pkg::CMD_PUSH_FRONT: begin
          nxt_we = 1'b1;
        end
        ole_pkg::CMD_PUSH_BACK: begin
          nxt_we = (cnt_q != '0);
          nxt_wa = tail_q;
          nxt_wd = new_q;
        end
        ole_pkg::CMD_INSERT_AFTER: begin
          nxt_we = 1'b1;
          nxt_wd = rd_nxt_q;
        end
        default: ;
      endcase
    end else if (cmd_i.link_pred) begin
      nxt_we = 1'b1;
      nxt_wa = cur_q;
      nxt_wd = new_q;
    end else if (cmd_i.remove && pos_q != '0) begin
      nxt_we = 1'b1;
      nxt_wa = prev_q;
      nxt_wd = rd_nxt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link) val_mem[new_q] <= val_q;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (cmd_i.remove) fs_mem[fs_cnt_q[IW-1:0]] <= cur_q;
    if (rd_en) begin
      rd_val_q <= val_mem[rd_addr];
      rd_nxt_q <= nxt_mem[rd_addr];
    end
    if (cmd_i.fs_read) fs_rd_q <= fs_mem[fs_top[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= ole_pkg::cmd_e'(command_i);
      key_q <= match_key_i;
      val_q <= new_value_i;
    end
    if (cmd_i.walk_start) begin
      cur_q <= head_q;
      pos_q <= '0;
    end else if (cmd_i.walk_step) begin
      prev_q <= cur_q;
      cur_q  <= rd_nxt_q;
      pos_q  <= pos_q + IW'(1);
    end
    if (cmd_i.set_status) status_q <= cmd_i.status_val;
    if (cmd_i.alloc) new_q <= (fs_cnt_q != '0) ? fs_rd_q : bump_q[IW-1:0];
    if (cmd_i.link) begin
      case (cmd_q)
        ole_pkg::CMD_PUSH_FRONT: begin
          head_q <= new_q;
          if (cnt_q == '0) tail_q <= new_q;
        end
        ole_pkg::CMD_PUSH_BACK: begin
          tail_q <= new_q;
          if (cnt_q == '0) head_q <= new_q;
        end
        ole_pkg::CMD_INSERT_AFTER: begin
          if (cur_q == tail_q) tail_q <= new_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.remove) begin
      if (pos_q == '0) head_q <= rd_nxt_q;
      if (cur_q == tail_q) tail_q <= prev_q;
    end
    if (cmd_i.emit_resp) begin
      out_status_q <= status_q;
      out_elem_q   <= '0;
      out_last_q   <= 1'b1;
      out_cnt_q    <= ole_pkg::COUNT_O_W'(cnt_q);
      out_sum_q    <= sum_q;
    end else if (cmd_i.emit_elem) begin
      out_status_q <= ole_pkg::ST_OK;
      out_elem_q   <= rd_val_q;
      out_last_q   <= at_end;
      out_cnt_q    <= ole_pkg::COUNT_O_W'(cnt_q);
      out_sum_q    <= sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sum_q       <= '0;
      bump_q      <= '0;
      fs_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.link) begin
        cnt_q <= cnt_q + CW'(1);
        sum_q <= sum_q + val_q;
      end else if (cmd_i.remove) begin
        cnt_q <= cnt_q - CW'(1);
        sum_q <= sum_q - rd_val_q;
      end
      if (cmd_i.alloc) begin
        if (fs_cnt_q != '0) fs_cnt_q <= fs_cnt_q - CW'(1);
        else                bump_q   <= bump_q + CW'(1);
      end else if (cmd_i.remove) begin
        fs_cnt_q <= fs_cnt_q + CW'(1);
      end
      if (cmd_i.emit_resp || cmd_i.emit_elem) out_valid_q <= 1'b1;
      else if (out_ready_i)                   out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign element_o     = out_elem_q;
  assign last_o        = out_last_q;
  assign entry_count_o = out_cnt_q;
  assign value_sum_o   = out_sum_q;

endmodule

`default_nettype wire

### hdl/ordered_list_engine.sv
`default_nettype none

// Ordered list of signed 32-bit values kept as a singly linked list in a
// DEPTH-slot node store (value and next pointer per slot, one read and one
// write port each). One command transaction is taken at a time; a command
// gives one result transaction, except listing, which gives one per entry
// with last set on the back entry (an empty list lists as one result with
// status empty). Every result carries the entry count and the wrapping sum
// after the command. Steps per command, from acceptance until the result is
// loaded into the output register:
//   push front/back: decode, allocate, link, respond (full: decode, respond)
//   pop front: decode, walk to the head, respond
//   search, remove key, pop back: decode, walk to the node reached, respond
//   insert after key: decode, walk to the key, allocate, link, link the
//     predecessor, respond (walk, respond when full or the key is missing)
//   any command other than a push on an empty list: decode, respond
//   listing: decode, then one result per cycle while the output is free
// The walk is bound by pointer chasing through the node store: one node per
// cycle on its read port; a listing walk holds while the output is busy.
// The next command is accepted the cycle after its predecessor's last result
// enters the output register, so a result may still wait there. Freed slots
// go on a free stack; never-used slots are handed out by a fill counter, so
// no clearing pass follows reset.

module ordered_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // command channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire [ole_pkg::CMD_W-1:0]           command_i,
  input  wire signed [ole_pkg::DATA_W-1:0]   match_key_i,
  input  wire signed [ole_pkg::DATA_W-1:0]   new_value_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [ole_pkg::STATUS_W-1:0]       status_o,
  output logic signed [ole_pkg::DATA_W-1:0]  element_o,
  output logic                               last_o,
  output logic [ole_pkg::COUNT_O_W-1:0]      entry_count_o,
  output logic signed [ole_pkg::DATA_W-1:0]  value_sum_o
);

  ole_pkg::ole_cmd_t  cmd;
  ole_pkg::ole_stat_t stat;

  // sequencer: decode, list walk, allocate/link, respond
  ole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // node store, pointers, counters and output register
  ole_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .command_i     (command_i),
    .match_key_i   (match_key_i),
    .new_value_i   (new_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .element_o     (element_o),
    .last_o        (last_o),
    .entry_count_o (entry_count_o),
    .value_sum_o   (value_sum_o)
  );

endmodule

`default_nettype wire

### sim/ole_checker.sv
`default_nettype none

module ole_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  input  wire                                in_ready_i,
  input  wire [ole_pkg::CMD_W-1:0]           command_i,
  input  wire signed [ole_pkg::DATA_W-1:0]   match_key_i,
  input  wire signed [ole_pkg::DATA_W-1:0]   new_value_i,
  input  wire                                out_valid_i,
  input  wire                                out_ready_i,
  input  wire [ole_pkg::STATUS_W-1:0]        status_i,
  input  wire signed [ole_pkg::DATA_W-1:0]   element_i,
  input  wire                                last_i,
  input  wire [ole_pkg::COUNT_O_W-1:0]       entry_count_i,
  input  wire signed [ole_pkg::DATA_W-1:0]   value_sum_i,
  output int                                 fail_count_o,
  output int                                 outstanding_o
);

  typedef struct packed {
    ole_pkg::status_e                status;
    logic [ole_pkg::DATA_W-1:0]      element;
    logic                            last;
    logic [ole_pkg::COUNT_O_W-1:0]   count;
    logic [ole_pkg::DATA_W-1:0]      sum;
  } list_result_t;

  // shadow copy of the list, front at slot 0
  logic [ole_pkg::DATA_W-1:0] slots [DEPTH];
  int unsigned                fill;
  logic [ole_pkg::DATA_W-1:0] total;
  list_result_t               expected_q [$];
  list_result_t               want;
  int                         fails;

  function automatic int unsigned find_first(logic [ole_pkg::DATA_W-1:0] key);
    for (int unsigned i = 0; i < fill; i++) begin
      if (slots[i] == key) return i;
    end
    return fill;
  endfunction

  task automatic place(int unsigned pos, logic [ole_pkg::DATA_W-1:0] v);
    for (int unsigned i = fill; i > pos; i--) slots[i] = slots[i-1];
    slots[pos] = v;
    fill++;
    total += v;
  endtask

  task automatic drop(int unsigned pos);
    total -= slots[pos];
    for (int unsigned i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
    fill--;
  endtask

  task automatic queue_result(ole_pkg::status_e st, logic [ole_pkg::DATA_W-1:0] elem,
                              logic lst);
    expected_q.push_back('{st, elem, lst, ole_pkg::COUNT_O_W'(fill), total});
  endtask

  task automatic predict_results(ole_pkg::cmd_e c, logic [ole_pkg::DATA_W-1:0] key,
                                 logic [ole_pkg::DATA_W-1:0] val);
    int unsigned      pos;
    ole_pkg::status_e st;
    st = ole_pkg::ST_OK;
    case (c)
      ole_pkg::CMD_PUSH_FRONT: begin
        if (fill >= DEPTH) st = ole_pkg::ST_FULL;
        else place(0, val);
      end
      ole_pkg::CMD_INSERT_AFTER: begin
        // missing key wins over a full store
        pos = find_first(key);
        if (pos >= fill) st = ole_pkg::ST_NOT_FOUND;
        else if (fill >= DEPTH) st = ole_pkg::ST_FULL;
        else place(pos + 1, val);
      end
      ole_pkg::CMD_PUSH_BACK: begin
        if (fill >= DEPTH) st = ole_pkg::ST_FULL;
        else place(fill, val);
      end
      ole_pkg::CMD_POP_FRONT: begin
        if (fill == 0) st = ole_pkg::ST_EMPTY;
        else drop(0);
      end
      ole_pkg::CMD_REMOVE_KEY: begin
        if (fill == 0) begin
          st = ole_pkg::ST_EMPTY;
        end else begin
          pos = find_first(key);
          if (pos >= fill) st = ole_pkg::ST_NOT_FOUND;
          else drop(pos);
        end
      end
      ole_pkg::CMD_POP_BACK: begin
        if (fill == 0) st = ole_pkg::ST_EMPTY;
        else drop(fill - 1);
      end
      ole_pkg::CMD_SEARCH: begin
        if (find_first(key) >= fill) st = ole_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
    if (c != ole_pkg::CMD_LIST) begin
      queue_result(st, '0, 1'b1);
    end else if (fill == 0) begin
      queue_result(ole_pkg::ST_EMPTY, '0, 1'b1);
    end else begin
      for (int unsigned i = 0; i < fill; i++) begin
        queue_result(ole_pkg::ST_OK, slots[i], i + 1 == fill);
      end
    end
  endtask

  task automatic check_field(string name, logic [ole_pkg::DATA_W-1:0] exp_v,
                             logic [ole_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill          = 0;
      total         = '0;
      fails         = 0;
      expected_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // results first: a result never belongs to a command taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, status %0h element %0h",
                   $time, status_i, element_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, status_i);
          check_field("element", want.element, element_i);
          check_field("last", want.last, last_i);
          check_field("entry_count", want.count, entry_count_i);
          check_field("value_sum", want.sum, value_sum_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_results(ole_pkg::cmd_e'(command_i), match_key_i, new_value_i);
      end
      fail_count_o  <= fails;
      outstanding_o <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

### sim/tb_ordered_list_engine.sv
`default_nettype none

// Stimulus and verdict for the ordered list engine. Prediction and
// comparison live in ole_checker.
module tb_ordered_list_engine;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDLE_PCT    = 24;
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no transaction
  localparam int unsigned POOL_N      = 8;
  localparam int unsigned DW          = ole_pkg::DATA_W;

  typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_e;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  ole_pkg::cmd_e            command   = ole_pkg::CMD_PUSH_FRONT;
  logic signed [DW-1:0]     match_key = '0;
  logic signed [DW-1:0]     new_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ole_pkg::STATUS_W-1:0]  status;
  logic signed [DW-1:0]          element;
  logic                          res_last;
  logic [ole_pkg::COUNT_O_W-1:0] entry_count;
  logic signed [DW-1:0]          value_sum;

  int          fail_count;
  int          outstanding;
  int          sent_count   = 0;
  int          result_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en      = 1'b1;  // sender gaps
  bit          stall_en     = 1'b1;  // receiver back-pressure

  // keys are mostly drawn from the same small pool as stored values, so
  // insert-after, remove-key and search hit real entries and duplicates
  logic [DW-1:0] value_pool [POOL_N];

  ordered_list_engine #(.DEPTH(DEPTH)) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .match_key_i   (match_key),
    .new_value_i   (new_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .element_o     (element),
    .last_o        (res_last),
    .entry_count_o (entry_count),
    .value_sum_o   (value_sum)
  );

  ole_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .command_i     (command),
    .match_key_i   (match_key),
    .new_value_i   (new_value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .element_i     (element),
    .last_i        (res_last),
    .entry_count_i (entry_count),
    .value_sum_i   (value_sum),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls unless a no-stall stretch is running
  always @(posedge clk) begin
    out_ready <= stall_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // watchdog on transaction activity; also counts results for the summary
  always @(posedge clk) begin
    if (out_valid && out_ready) result_count <= result_count + 1;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("ordered_list_engine: mismatch");
      $finish;
    end
  end

  // One command transaction. A gap, when taken, lowers valid in the same
  // step the previous command was accepted; otherwise valid stays high and
  // only the payload moves on.
  task automatic send(ole_pkg::cmd_e c, logic [DW-1:0] key, logic [DW-1:0] val);
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid  <= 1'b1;
    command   <= c;
    match_key <= key;
    new_value <= val;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [DW-1:0] pick_operand(int unsigned pool_pct);
    if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(POOL_N-1)];
    return $urandom;
  endfunction

  function automatic ole_pkg::cmd_e pick_command(phase_e ph);
    int unsigned r;
    int unsigned ins_pct;
    int unsigned rem_pct;
    r = $urandom_range(99);
    case (ph)
      PH_FILL: begin
        ins_pct = 70;
        rem_pct = 10;
      end
      PH_MIX: begin
        ins_pct = 40;
        rem_pct = 35;
      end
      default: begin
        ins_pct = 15;
        rem_pct = 65;
      end
    endcase
    if (r < ins_pct) begin
      return ole_pkg::cmd_e'(ole_pkg::CMD_W'(ole_pkg::CMD_PUSH_FRONT + $urandom_range(2)));
    end
    if (r < ins_pct + rem_pct) begin
      return ole_pkg::cmd_e'(ole_pkg::CMD_W'(ole_pkg::CMD_POP_FRONT + $urandom_range(2)));
    end
    if (r < ins_pct + rem_pct + (100 - ins_pct - rem_pct) / 2) return ole_pkg::CMD_SEARCH;
    return ole_pkg::CMD_LIST;
  endfunction

  task automatic run_phase(phase_e ph, int n);
    repeat (n) begin
      if ($urandom_range(19) == 0) value_pool[$urandom_range(POOL_N-1)] = $urandom;
      send(pick_command(ph), pick_operand(60), pick_operand(50));
    end
  endtask

  initial begin
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every removal, search, listing and insert-after
    send(ole_pkg::CMD_LIST, $urandom, $urandom);
    send(ole_pkg::CMD_POP_FRONT, $urandom, $urandom);
    send(ole_pkg::CMD_REMOVE_KEY, $urandom, $urandom);
    send(ole_pkg::CMD_POP_BACK, $urandom, $urandom);
    send(ole_pkg::CMD_SEARCH, $urandom, $urandom);
    send(ole_pkg::CMD_INSERT_AFTER, 32'h0, 32'h1234_5678);
    // extremes of the value range; sum wraps
    send(ole_pkg::CMD_PUSH_FRONT, $urandom, 32'h0);
    send(ole_pkg::CMD_PUSH_BACK, $urandom, 32'h7fff_ffff);
    send(ole_pkg::CMD_PUSH_FRONT, $urandom, 32'h8000_0000);
    send(ole_pkg::CMD_PUSH_BACK, $urandom, 32'hffff_ffff);
    send(ole_pkg::CMD_INSERT_AFTER, 32'h7fff_ffff, 32'h5a5a_a5a5);
    send(ole_pkg::CMD_INSERT_AFTER, 32'h0000_3039, 32'h1);
    send(ole_pkg::CMD_INSERT_AFTER, 32'h0, 32'h0);           // duplicate value
    send(ole_pkg::CMD_SEARCH, 32'h8000_0000, $urandom);
    send(ole_pkg::CMD_SEARCH, 32'h0000_0001, $urandom);
    send(ole_pkg::CMD_LIST, $urandom, $urandom);
    send(ole_pkg::CMD_REMOVE_KEY, 32'h0, $urandom);          // first of two equal
    send(ole_pkg::CMD_REMOVE_KEY, 32'h0000_0309, $urandom);  // missing key
    send(ole_pkg::CMD_POP_FRONT, $urandom, $urandom);
    send(ole_pkg::CMD_POP_BACK, $urandom, $urandom);
    send(ole_pkg::CMD_LIST, $urandom, $urandom);

    // insert-heavy: reaches a full store and its refusals
    run_phase(PH_FILL, 70);
    wait_for_results();
    // no gaps or stalls at all for a stretch, then back to random idling
    idle_en  = 1'b0;
    stall_en = 1'b0;
    run_phase(PH_MIX, 50);
    idle_en  = 1'b1;
    stall_en = 1'b1;
    run_phase(PH_MIX, 40);
    wait_for_results();
    // removal-heavy: drains to empty and hits the empty cases again
    run_phase(PH_DRAIN, 50);
    wait_for_results();
    repeat (DEPTH + 8) @(posedge clk);

    $display("%0d commands over directed, fill, mixed and drain phases", sent_count);
    $display("%0d result transactions checked", result_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ordered_list_engine: match");
    end else begin
      $display("ordered_list_engine: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
